### hw/rtl/telnet_option_negotiator_assert.svh
// ---------------------------------------------------------------------------
// Telnet option negotiator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TON_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TON_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ton_pkg.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator package
// Shared types, codes and lookup functions for the negotiator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ton_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 2;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_RECV  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  localparam logic [2:0] REQ_BETTERNOT = 3'd0;
  localparam logic [2:0] REQ_BETTER    = 3'd1;
  localparam logic [2:0] REQ_MUSTNOT   = 3'd2;
  localparam logic [2:0] REQ_MUST      = 3'd3;
  localparam logic [2:0] REQ_NEUTRAL   = 3'd4;

  localparam logic [2:0] ENT_BINARY  = 3'd0;
  localparam logic [2:0] ENT_ECHO    = 3'd1;
  localparam logic [2:0] ENT_SGA     = 3'd2;
  localparam logic [2:0] ENT_TTYPE   = 3'd3;
  localparam logic [2:0] ENT_DEFAULT = 3'd4;

  localparam logic [7:0] OPT_CODE_BINARY = 8'd0;
  localparam logic [7:0] OPT_CODE_ECHO   = 8'd1;
  localparam logic [7:0] OPT_CODE_SGA    = 8'd3;
  localparam logic [7:0] OPT_CODE_TTYPE  = 8'd24;

  localparam logic [CFG_ADDR_W-1:0] CFG_BINARY_LOCAL  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BINARY_REMOTE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LINE_MODE     = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TTYPE_REFUSE  = 2'd3;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] verb;
    logic [7:0] option;
    logic [2:0] entry;
  } item_t;

  typedef struct packed {
    logic [1:0] binary_local_mode;
    logic [1:0] binary_remote_mode;
    logic [1:0] line_mode;
    logic       ttype_refuse;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [2:0] entry_of(input logic [7:0] opt);
    logic [2:0] e;
    case (opt)
      OPT_CODE_BINARY: e = ENT_BINARY;
      OPT_CODE_ECHO:   e = ENT_ECHO;
      OPT_CODE_SGA:    e = ENT_SGA;
      OPT_CODE_TTYPE:  e = ENT_TTYPE;
      default:         e = ENT_DEFAULT;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] option_of(input logic [1:0] ent);
    logic [7:0] o;
    case (ent)
      2'd0:    o = OPT_CODE_BINARY;
      2'd1:    o = OPT_CODE_ECHO;
      2'd2:    o = OPT_CODE_SGA;
      default: o = OPT_CODE_TTYPE;
    endcase
    return o;
  endfunction

  function automatic logic [2:0] req_pos(input logic [1:0] mode);
    logic [2:0] r;
    case (mode)
      2'd0:    r = REQ_BETTERNOT;
      2'd1:    r = REQ_BETTER;
      2'd2:    r = REQ_MUSTNOT;
      default: r = REQ_MUST;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] req_neg(input logic [1:0] mode);
    logic [2:0] r;
    case (mode)
      2'd0:    r = REQ_BETTER;
      2'd1:    r = REQ_BETTERNOT;
      2'd2:    r = REQ_MUST;
      default: r = REQ_MUSTNOT;
    endcase
    return r;
  endfunction

  function automatic logic wants_on(input logic [2:0] req);
    return (req == REQ_BETTER) || (req == REQ_MUST);
  endfunction

  function automatic logic wants_off(input logic [2:0] req);
    return (req == REQ_BETTERNOT) || (req == REQ_MUSTNOT);
  endfunction

  // WILL<->DO, WONT<->DONT
  function automatic logic [1:0] posi_verb(input logic [1:0] v);
    return v ^ 2'b10;
  endfunction

  // WILL->DONT, WONT->DO, DO->WONT, DONT->WILL
  function automatic logic [1:0] nega_verb(input logic [1:0] v);
    return v ^ 2'b11;
  endfunction

endpackage

### hw/rtl/ton_front.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator front end
// Accepts requests, decodes the option code to a table entry and queues them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ton_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      cmd,
  input  logic [1:0]      verb,
  input  logic [7:0]      option,
  input  ton_pkg::qstat_t q_stat,
  output logic            push,
  output ton_pkg::item_t  push_data
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_data.cmd    = ton_pkg::cmd_t'(cmd);
    push_data.verb   = verb;
    push_data.option = option;
    push_data.entry  = ton_pkg::entry_of(option);
  end

endmodule

### hw/rtl/ton_queue.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator request queue
// Small FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ton_queue #(
  parameter int DEPTH = ton_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ton_pkg::item_t  push_data,
  input  logic            pop,
  output ton_pkg::item_t  pop_data,
  output ton_pkg::qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ton_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ton_back.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator back end
// Holds the option table, carries out queued requests and drives the result
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ton_back (
  input  logic           clk,
  input  logic           rst,
  input  ton_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  ton_pkg::item_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           reply_valid,
  output logic [1:0]     reply_verb,
  output logic [7:0]     reply_option,
  output logic           refused,
  output logic           binary_send,
  output logic           binary_receive,
  output logic           sga_active,
  output logic           last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [4:0] en_l, en_l_next, en_r, en_r_next;
  logic [4:0] pd_l, pd_l_next, pd_r, pd_r_next;
  logic [2:0] lreq_bin, lreq_bin_next, rreq_bin, rreq_bin_next;
  logic [2:0] rreq_echo, rreq_echo_next, rreq_sga, rreq_sga_next;
  logic [2:0] lreq_tt, lreq_tt_next;
  logic [7:0] walk_mask, walk_mask_next;

  logic       can_load;
  logic       load;
  logic       res_valid, res_refused, res_last;
  logic [1:0] res_verb;
  logic [7:0] res_option;

  logic [2:0] lr_new [4];
  logic [2:0] rr_new [4];
  logic [7:0] send_mask;
  logic [2:0] walk_k;
  logic [7:0] walk_rest;

  logic       rx_remote, rx_want, rx_en, rx_pd, rx_en_n, rx_pd_n;
  logic [2:0] rx_req, rx_must_neg, rx_better_neg;

  assign can_load = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && q_valid && can_load;

  // Requirements after a send-requests load, and the sides to ask for
  always_comb begin
    lr_new[0] = ton_pkg::req_pos(cfg.binary_local_mode);
    lr_new[1] = ton_pkg::REQ_MUSTNOT;
    lr_new[2] = ton_pkg::REQ_BETTER;
    lr_new[3] = cfg.ttype_refuse ? ton_pkg::REQ_MUSTNOT : ton_pkg::REQ_NEUTRAL;
    rr_new[0] = ton_pkg::req_pos(cfg.binary_remote_mode);
    rr_new[1] = ton_pkg::req_neg(cfg.line_mode);
    rr_new[2] = ton_pkg::req_neg(cfg.line_mode);
    rr_new[3] = ton_pkg::REQ_MUSTNOT;
    for (int i = 0; i < 4; i++) begin
      send_mask[2*i]   = (ton_pkg::wants_off(lr_new[i]) && en_l[i]) ||
                         (ton_pkg::wants_on(lr_new[i]) && !en_l[i]);
      send_mask[2*i+1] = (ton_pkg::wants_off(rr_new[i]) && en_r[i]) ||
                         (ton_pkg::wants_on(rr_new[i]) && !en_r[i]);
    end
  end

  // Lowest pending side of the walk
  always_comb begin
    walk_k = '0;
    for (int i = 7; i >= 0; i--) begin
      if (walk_mask[i]) begin
        walk_k = 3'(i);
      end
    end
    walk_rest = walk_mask & ~(8'b1 << walk_k);
  end

  // Received command on the side it addresses
  always_comb begin
    rx_remote     = !q_data.verb[1];
    rx_want       = !q_data.verb[0];
    rx_must_neg   = rx_want ? ton_pkg::REQ_MUSTNOT : ton_pkg::REQ_MUST;
    rx_better_neg = rx_want ? ton_pkg::REQ_BETTERNOT : ton_pkg::REQ_BETTER;
    rx_en         = rx_remote ? en_r[q_data.entry] : en_l[q_data.entry];
    rx_pd         = rx_remote ? pd_r[q_data.entry] : pd_l[q_data.entry];
    if (rx_remote) begin
      case (q_data.entry)
        ton_pkg::ENT_BINARY: rx_req = rreq_bin;
        ton_pkg::ENT_ECHO:   rx_req = rreq_echo;
        ton_pkg::ENT_SGA:    rx_req = rreq_sga;
        default:             rx_req = ton_pkg::REQ_MUSTNOT;
      endcase
    end else begin
      case (q_data.entry)
        ton_pkg::ENT_BINARY: rx_req = lreq_bin;
        ton_pkg::ENT_ECHO:   rx_req = ton_pkg::REQ_MUSTNOT;
        ton_pkg::ENT_SGA:    rx_req = ton_pkg::REQ_BETTER;
        ton_pkg::ENT_TTYPE:  rx_req = lreq_tt;
        default:             rx_req = ton_pkg::REQ_MUSTNOT;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    en_l_next      = en_l;
    en_r_next      = en_r;
    pd_l_next      = pd_l;
    pd_r_next      = pd_r;
    lreq_bin_next  = lreq_bin;
    rreq_bin_next  = rreq_bin;
    rreq_echo_next = rreq_echo;
    rreq_sga_next  = rreq_sga;
    lreq_tt_next   = lreq_tt;
    walk_mask_next = walk_mask;
    load           = 1'b0;
    res_valid      = 1'b0;
    res_verb       = ton_pkg::VERB_WILL;
    res_option     = '0;
    res_refused    = 1'b0;
    res_last       = 1'b1;
    rx_en_n        = rx_en;
    rx_pd_n        = rx_pd;

    case (state)
      ST_IDLE: begin
        if (pop) begin
          case (q_data.cmd)
            ton_pkg::CMD_RESET: begin
              en_l_next = '0;
              en_r_next = '0;
              pd_l_next = '0;
              pd_r_next = '0;
              load      = 1'b1;
            end
            ton_pkg::CMD_SEND: begin
              lreq_bin_next  = lr_new[0];
              rreq_bin_next  = rr_new[0];
              rreq_echo_next = rr_new[1];
              rreq_sga_next  = rr_new[2];
              lreq_tt_next   = lr_new[3];
              for (int i = 0; i < 4; i++) begin
                pd_l_next[i] = pd_l[i] | send_mask[2*i];
                pd_r_next[i] = pd_r[i] | send_mask[2*i+1];
              end
              if (send_mask == '0) begin
                load = 1'b1;
              end else begin
                walk_mask_next = send_mask;
                state_next     = ST_WALK;
              end
            end
            ton_pkg::CMD_RECV: begin
              load = 1'b1;
              if (rx_req == rx_must_neg || rx_req == rx_better_neg) begin
                if (rx_pd) begin
                  rx_pd_n = 1'b0;
                  if (rx_req == rx_must_neg) begin
                    res_refused = 1'b1;
                  end else if (rx_en != rx_want) begin
                    rx_en_n   = rx_want;
                    res_valid = 1'b1;
                    res_verb  = ton_pkg::posi_verb(q_data.verb);
                  end
                end else begin
                  res_valid = 1'b1;
                  res_verb  = ton_pkg::nega_verb(q_data.verb);
                end
              end else begin
                if (rx_pd) begin
                  rx_pd_n = 1'b0;
                end else if (rx_en != rx_want) begin
                  res_valid = 1'b1;
                  res_verb  = ton_pkg::posi_verb(q_data.verb);
                end
                rx_en_n = rx_want;
              end
              if (res_valid) begin
                res_option = q_data.option;
              end
              if (rx_remote) begin
                en_r_next[q_data.entry] = rx_en_n;
                pd_r_next[q_data.entry] = rx_pd_n;
              end else begin
                en_l_next[q_data.entry] = rx_en_n;
                pd_l_next[q_data.entry] = rx_pd_n;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (can_load) begin
          load       = 1'b1;
          res_valid  = 1'b1;
          res_option = ton_pkg::option_of(walk_k[2:1]);
          if (walk_k[0]) begin
            res_verb = en_r[walk_k[2:1]] ? ton_pkg::VERB_DONT : ton_pkg::VERB_DO;
          end else begin
            res_verb = en_l[walk_k[2:1]] ? ton_pkg::VERB_WONT : ton_pkg::VERB_WILL;
          end
          res_last       = (walk_rest == '0);
          walk_mask_next = walk_rest;
          if (walk_rest == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      en_l      <= '0;
      en_r      <= '0;
      pd_l      <= '0;
      pd_r      <= '0;
      lreq_bin  <= ton_pkg::REQ_BETTER;
      rreq_bin  <= ton_pkg::REQ_BETTER;
      rreq_echo <= ton_pkg::REQ_BETTER;
      rreq_sga  <= ton_pkg::REQ_MUST;
      lreq_tt   <= ton_pkg::REQ_NEUTRAL;
      walk_mask <= '0;
    end else begin
      state     <= state_next;
      en_l      <= en_l_next;
      en_r      <= en_r_next;
      pd_l      <= pd_l_next;
      pd_r      <= pd_r_next;
      lreq_bin  <= lreq_bin_next;
      rreq_bin  <= rreq_bin_next;
      rreq_echo <= rreq_echo_next;
      rreq_sga  <= rreq_sga_next;
      lreq_tt   <= lreq_tt_next;
      walk_mask <= walk_mask_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status bits show the table after the request has been handled
  always_ff @(posedge clk) begin
    if (load) begin
      reply_valid    <= res_valid;
      reply_verb     <= res_verb;
      reply_option   <= res_option;
      refused        <= res_refused;
      last           <= res_last;
      binary_send    <= en_l_next[ton_pkg::ENT_BINARY];
      binary_receive <= en_r_next[ton_pkg::ENT_BINARY];
      sga_active     <= en_r_next[ton_pkg::ENT_SGA];
    end
  end

endmodule

### hw/rtl/telnet_option_negotiator.sv
// ---------------------------------------------------------------------------
// Telnet option negotiator
// Requests enter through a small queue and reach the back end one at a time.
// A reset or received-command request gives one result in the cycle after it
// leaves the queue. A send-requests request first loads the requirements and
// then gives one result per WILL/WONT/DO/DONT issued (up to eight), waiting
// while the receiver stalls, since the back end walks the option sides one at
// a time into a single result register; with nothing to ask it gives one
// empty result. A request is written into the queue before it starts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_option_negotiator #(
  parameter int QUEUE_DEPTH = ton_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ton_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ton_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [1:0]                     verb,
  input  logic [7:0]                     option,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           reply_valid,
  output logic [1:0]                     reply_verb,
  output logic [7:0]                     reply_option,
  output logic                           refused,
  output logic                           binary_send,
  output logic                           binary_receive,
  output logic                           sga_active,
  output logic                           last
);

`include "telnet_option_negotiator_assert.svh"

  ton_pkg::cfg_t   cfg;
  ton_pkg::qstat_t q_stat;
  ton_pkg::item_t  push_data;
  ton_pkg::item_t  pop_data;
  logic            push;
  logic            pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.binary_local_mode  <= 2'd1;
      cfg.binary_remote_mode <= 2'd1;
      cfg.line_mode          <= 2'd0;
      cfg.ttype_refuse       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ton_pkg::CFG_BINARY_LOCAL:  cfg.binary_local_mode  <= cfg_data[1:0];
        ton_pkg::CFG_BINARY_REMOTE: cfg.binary_remote_mode <= cfg_data[1:0];
        ton_pkg::CFG_LINE_MODE:     cfg.line_mode          <= cfg_data[1:0];
        ton_pkg::CFG_TTYPE_REFUSE:  cfg.ttype_refuse       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ton_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .verb      (verb),
    .option    (option),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ton_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ton_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (!q_stat.empty),
    .q_data         (pop_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reply_valid    (reply_valid),
    .reply_verb     (reply_verb),
    .reply_option   (reply_option),
    .refused        (refused),
    .binary_send    (binary_send),
    .binary_receive (binary_receive),
    .sga_active     (sga_active),
    .last           (last)
  );

  `TON_ASSERT_IMP(a_full_blocks_input, q_stat.full, !in_ready, "request taken while queue full")
  `TON_ASSERT_NXT(a_push_fills_queue, push && q_stat.empty, !q_stat.empty, "queued request lost")
  `TON_ASSERT_IMP(a_refusal_silent, out_valid && refused, !reply_valid, "refusal carries a reply")
  `TON_ASSERT_IMP(a_empty_reply_clear, out_valid && !reply_valid, reply_option == 8'd0 && reply_verb == ton_pkg::VERB_WILL, "empty result has reply fields set")

endmodule

### dv/telnet_option_negotiator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Telnet option negotiator testbench
// Offers reset, send-requests, received-command and no-op requests under
// random idling on both handshakes. Replies are predicted per request from a
// private copy of the option table and checked field by field, in order.
// ---------------------------------------------------------------------------

module telnet_option_negotiator_tb;
  import ton_pkg::*;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_verb;
    logic [7:0] reply_option;
    logic       refused;
    logic       binary_send;
    logic       binary_receive;
    logic       sga_active;
    logic       last;
  } reply_t;

  localparam int SLOTS        = 5;
  localparam int DEFAULT_SLOT = 4;

  class reply_scoreboard;
    reply_t     awaited_replies[$];
    int         errors;
    logic [1:0] bin_local_mode, bin_remote_mode, line_mode;
    logic       ttype_refuse;
    bit         local_on[SLOTS], remote_on[SLOTS];
    bit         local_asked[SLOTS], remote_asked[SLOTS];
    logic [2:0] local_req[SLOTS], remote_req[SLOTS];
    logic [7:0] slot_code[4];

    function new();
      errors          = 0;
      slot_code       = '{OPT_CODE_BINARY, OPT_CODE_ECHO, OPT_CODE_SGA, OPT_CODE_TTYPE};
      bin_local_mode  = 2'd1;
      bin_remote_mode = 2'd1;
      line_mode       = 2'd0;
      ttype_refuse    = 1'b0;
      local_req  = '{REQ_BETTER, REQ_MUSTNOT, REQ_BETTER, REQ_NEUTRAL, REQ_MUSTNOT};
      remote_req = '{REQ_BETTER, REQ_BETTER, REQ_MUST, REQ_MUSTNOT, REQ_MUSTNOT};
      clear_session();
    endfunction

    function void clear_session();
      for (int i = 0; i < SLOTS; i++) begin
        local_on[i]     = 1'b0;
        remote_on[i]    = 1'b0;
        local_asked[i]  = 1'b0;
        remote_asked[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [1:0] val);
      case (idx)
        CFG_BINARY_LOCAL:  bin_local_mode = val;
        CFG_BINARY_REMOTE: bin_remote_mode = val;
        CFG_LINE_MODE:     line_mode = val;
        CFG_TTYPE_REFUSE:  ttype_refuse = val[0];
        default: ;
      endcase
    endfunction

    // Line mode uses the same four codes with on and off swapped
    function logic [2:0] mode_req(logic [1:0] m, bit inverted);
      logic [2:0] r;
      case (m)
        2'd0:    r = inverted ? REQ_BETTER    : REQ_BETTERNOT;
        2'd1:    r = inverted ? REQ_BETTERNOT : REQ_BETTER;
        2'd2:    r = inverted ? REQ_MUST      : REQ_MUSTNOT;
        default: r = inverted ? REQ_MUSTNOT   : REQ_MUST;
      endcase
      return r;
    endfunction

    function bit asks_off(logic [2:0] r);
      return (r == REQ_MUSTNOT) || (r == REQ_BETTERNOT);
    endfunction

    function bit asks_on(logic [2:0] r);
      return (r == REQ_MUST) || (r == REQ_BETTER);
    endfunction

    function void add_reply(bit valid, logic [1:0] v, logic [7:0] o, bit ref_flag);
      reply_t r;
      r.reply_valid    = valid;
      r.reply_verb     = v;
      r.reply_option   = o;
      r.refused        = ref_flag;
      r.binary_send    = local_on[0];
      r.binary_receive = remote_on[0];
      r.sga_active     = remote_on[2];
      r.last           = 1'b0;
      awaited_replies.push_back(r);
    endfunction

    function void predict_send();
      int n;
      local_req[0]  = mode_req(bin_local_mode, 1'b0);
      remote_req[0] = mode_req(bin_remote_mode, 1'b0);
      remote_req[1] = mode_req(line_mode, 1'b1);
      remote_req[2] = remote_req[1];
      local_req[3]  = ttype_refuse ? REQ_MUSTNOT : REQ_NEUTRAL;
      n = 0;
      for (int i = 0; i < 4; i++) begin
        if (asks_off(local_req[i]) && local_on[i]) begin
          local_asked[i] = 1'b1;
          add_reply(1'b1, VERB_WONT, slot_code[i], 1'b0);
          n++;
        end else if (asks_on(local_req[i]) && !local_on[i]) begin
          local_asked[i] = 1'b1;
          add_reply(1'b1, VERB_WILL, slot_code[i], 1'b0);
          n++;
        end
        if (asks_off(remote_req[i]) && remote_on[i]) begin
          remote_asked[i] = 1'b1;
          add_reply(1'b1, VERB_DONT, slot_code[i], 1'b0);
          n++;
        end else if (asks_on(remote_req[i]) && !remote_on[i]) begin
          remote_asked[i] = 1'b1;
          add_reply(1'b1, VERB_DO, slot_code[i], 1'b0);
          n++;
        end
      end
      if (n == 0)
        add_reply(1'b0, '0, '0, 1'b0);
    endfunction

    function void predict_command(logic [1:0] v, logic [7:0] o);
      int         s;
      bit         far_side, want, valid, ref_flag, on_now, asked;
      logic [2:0] req, must_against, better_against;
      logic [1:0] agree, decline, rverb;
      s = DEFAULT_SLOT;
      for (int i = 0; i < 4; i++)
        if (slot_code[i] == o) s = i;
      far_side       = (v == VERB_WILL) || (v == VERB_WONT);
      want           = (v == VERB_WILL) || (v == VERB_DO);
      must_against   = want ? REQ_MUSTNOT : REQ_MUST;
      better_against = want ? REQ_BETTERNOT : REQ_BETTER;
      case (v)
        VERB_WILL: begin agree = VERB_DO;   decline = VERB_DONT; end
        VERB_WONT: begin agree = VERB_DONT; decline = VERB_DO;   end
        VERB_DO:   begin agree = VERB_WILL; decline = VERB_WONT; end
        default:   begin agree = VERB_WONT; decline = VERB_WILL; end
      endcase
      req      = far_side ? remote_req[s] : local_req[s];
      on_now   = far_side ? remote_on[s] : local_on[s];
      asked    = far_side ? remote_asked[s] : local_asked[s];
      valid    = 1'b0;
      rverb    = '0;
      ref_flag = 1'b0;
      if (req == must_against || req == better_against) begin
        if (asked) begin
          // peer answered our own request against what we asked for
          asked = 1'b0;
          if (req == must_against) begin
            ref_flag = 1'b1;
          end else if (on_now != want) begin
            on_now = want;
            valid  = 1'b1;
            rverb  = agree;
          end
        end else begin
          valid = 1'b1;
          rverb = decline;
        end
      end else begin
        if (asked)
          asked = 1'b0;
        else if (on_now != want) begin
          valid = 1'b1;
          rverb = agree;
        end
        on_now = want;
      end
      if (far_side) begin
        remote_on[s]    = on_now;
        remote_asked[s] = asked;
      end else begin
        local_on[s]    = on_now;
        local_asked[s] = asked;
      end
      add_reply(valid, rverb, valid ? o : 8'd0, ref_flag);
    endfunction

    function void predict_replies(logic [1:0] c, logic [1:0] v, logic [7:0] o);
      reply_t t;
      case (cmd_t'(c))
        CMD_RESET: begin
          clear_session();
          add_reply(1'b0, '0, '0, 1'b0);
        end
        CMD_SEND: predict_send();
        CMD_RECV: predict_command(v, o);
        default:  add_reply(1'b0, '0, '0, 1'b0);
      endcase
      t = awaited_replies.pop_back();
      t.last = 1'b1;
      awaited_replies.push_back(t);
    endfunction

    task report_mismatch(string msg);
      if (errors < 20)
        $display("%0t ns mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_reply(reply_t got);
      reply_t w;
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      w = awaited_replies.pop_front();
      if (got.reply_valid !== w.reply_valid)
        report_mismatch($sformatf("reply_valid %b, expected %b", got.reply_valid,
                                  w.reply_valid));
      if (got.reply_verb !== w.reply_verb)
        report_mismatch($sformatf("reply_verb %0d, expected %0d", got.reply_verb,
                                  w.reply_verb));
      if (got.reply_option !== w.reply_option)
        report_mismatch($sformatf("reply_option %0d, expected %0d", got.reply_option,
                                  w.reply_option));
      if (got.refused !== w.refused)
        report_mismatch($sformatf("refused %b, expected %b", got.refused, w.refused));
      if (got.binary_send !== w.binary_send)
        report_mismatch($sformatf("binary_send %b, expected %b", got.binary_send,
                                  w.binary_send));
      if (got.binary_receive !== w.binary_receive)
        report_mismatch($sformatf("binary_receive %b, expected %b", got.binary_receive,
                                  w.binary_receive));
      if (got.sga_active !== w.sga_active)
        report_mismatch($sformatf("sga_active %b, expected %b", got.sga_active,
                                  w.sga_active));
      if (got.last !== w.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, w.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            cmd;
  logic [1:0]            verb;
  logic [7:0]            option;
  logic                  out_valid;
  logic                  out_ready;
  logic                  reply_valid;
  logic [1:0]            reply_verb;
  logic [7:0]            reply_option;
  logic                  refused;
  logic                  binary_send;
  logic                  binary_receive;
  logic                  sga_active;
  logic                  last;

  bit steady;
  bit hold_off_request;

  reply_scoreboard sb = new();

  telnet_option_negotiator uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .verb           (verb),
    .option         (option),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reply_valid    (reply_valid),
    .reply_verb     (reply_verb),
    .reply_option   (reply_option),
    .refused        (refused),
    .binary_send    (binary_send),
    .binary_receive (binary_receive),
    .sga_active     (sga_active),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.predict_replies(cmd, verb, option);
    if (!rst && out_valid && out_ready)
      sb.check_reply({reply_valid, reply_verb, reply_option, refused,
                      binary_send, binary_receive, sga_active, last});
  end

  // Mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] known_code();
    case ($urandom_range(0, 3))
      0:       return OPT_CODE_BINARY;
      1:       return OPT_CODE_ECHO;
      2:       return OPT_CODE_SGA;
      default: return OPT_CODE_TTYPE;
    endcase
  endfunction

  task automatic offer_request(logic [1:0] c, logic [1:0] v, logic [7:0] o);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    verb     <= v;
    option   <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and let every awaited reply drain
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [1:0] bl, logic [1:0] br, logic [1:0] lm, logic tr);
    write_reg(CFG_BINARY_LOCAL, bl);
    write_reg(CFG_BINARY_REMOTE, br);
    write_reg(CFG_LINE_MODE, lm);
    write_reg(CFG_TTYPE_REFUSE, {1'b0, tr});
  endtask

  task automatic random_phase(int count);
    int done, r, k;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // request round followed by answers from the peer
        offer_request(CMD_SEND, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        k = $urandom_range(2, 6);
        for (int i = 0; i < k; i++)
          offer_request(CMD_RECV, 2'($urandom_range(0, 3)), known_code());
        done += k + 1;
      end else if (r < 70) begin
        offer_request(CMD_RESET, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        done++;
      end else if (r < 93) begin
        offer_request(CMD_RECV, 2'($urandom_range(0, 3)),
                      $urandom_range(0, 1) ? known_code() : 8'($urandom_range(0, 255)));
        done++;
      end else begin
        offer_request(CMD_NONE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    finish_phase();
  endtask

  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    steady           = 1'b0;
    hold_off_request = 1'b0;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd      <= CMD_NONE;
    verb     <= '0;
    option   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: ask, then answer each kind of verb
    offer_request(CMD_SEND, VERB_WILL, 8'd0);
    offer_request(CMD_RECV, VERB_WILL, OPT_CODE_BINARY);
    offer_request(CMD_RECV, VERB_WONT, OPT_CODE_ECHO);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_BINARY);
    offer_request(CMD_RECV, VERB_DONT, OPT_CODE_SGA);
    offer_request(CMD_RECV, VERB_WILL, OPT_CODE_TTYPE);
    offer_request(CMD_RECV, VERB_DO, 8'd200);
    offer_request(CMD_RECV, VERB_WILL, 8'd255);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_ECHO);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_TTYPE);
    offer_request(CMD_NONE, VERB_DONT, 8'd255);
    offer_request(CMD_RECV, VERB_WONT, OPT_CODE_BINARY);
    finish_phase();

    // Hard requirements: answers against them raise the refusal flag
    write_all(2'd3, 2'd2, 2'd2, 1'b1);
    offer_request(CMD_SEND, VERB_DONT, 8'd170);
    offer_request(CMD_RECV, VERB_WILL, OPT_CODE_BINARY);
    offer_request(CMD_RECV, VERB_WONT, OPT_CODE_SGA);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_TTYPE);
    offer_request(CMD_RECV, VERB_WONT, OPT_CODE_ECHO);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_SGA);
    offer_request(CMD_RESET, VERB_DONT, 8'd255);
    offer_request(CMD_SEND, VERB_WILL, 8'd85);
    offer_request(CMD_RECV, VERB_DONT, OPT_CODE_BINARY);
    finish_phase();

    // Soft refusals: unsolicited offers get declined
    write_all(2'd0, 2'd0, 2'd1, 1'b0);
    offer_request(CMD_SEND, VERB_WILL, 8'd0);
    offer_request(CMD_RECV, VERB_WILL, OPT_CODE_BINARY);
    offer_request(CMD_RECV, VERB_DO, OPT_CODE_BINARY);
    offer_request(CMD_RECV, VERB_WILL, OPT_CODE_ECHO);
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      if (p == 0)
        write_all(2'd3, 2'd3, 2'd3, 1'b1);
      else if (p == 1)
        write_all(2'd0, 2'd0, 2'd0, 1'b0);
      else
        repeat ($urandom_range(1, 4))
          write_reg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      steady = (p == 5);
      // Long receiver stall while requests keep coming
      if (p == 2)
        hold_off_request = 1'b1;
      random_phase(11);
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ton_pkg.sv
hw/rtl/ton_front.sv
hw/rtl/ton_queue.sv
hw/rtl/ton_back.sv
hw/rtl/telnet_option_negotiator.sv
dv/telnet_option_negotiator_tb.sv
